// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrm_pkg
// Types and constants for the rational reduction unit.
// ----------------------------------------------------------------------------
package rrm_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DEN_W  = 31;

   typedef struct packed {
      logic signed [31:0] numerator;
      logic signed [31:0] denominator;
   } req_type;

   typedef struct packed {
      logic signed [31:0] reduced_numerator;
      logic        [30:0] reduced_denominator;
      logic signed [31:0] whole_part;
      logic signed [31:0] fraction_remainder;
      logic               zero_denominator;
   } rsp_type;

   // divider operand select
   typedef enum logic [1:0] {
      DSEL_GCD   = 2'd0,  // a % b, Euclid step
      DSEL_NUM   = 2'd1,  // |n| / g
      DSEL_DEN   = 2'd2,  // |d| / g
      DSEL_WHOLE = 2'd3   // |rn| / rd
   } dsel_type;

   typedef struct packed {
      logic     load;       // capture request operands
      logic     div_start;  // launch a division
      dsel_type dsel;       // operands of that division
      logic     div_store;  // store the finished division
      logic     done;       // drive the result strobe
   } cmd_type;

   typedef struct packed {
      logic zero_den;
      logic b_zero;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/rational_reduce_mixed_unit.sv =====
// ----------------------------------------------------------------------------
// rational_reduce_mixed_unit
// Reduces a signed fraction by its gcd and gives the mixed-form split.
// ----------------------------------------------------------------------------
// Sequence: load, then one division per Euclid step (at most about 46 steps),
//   then the numerator, denominator and whole-part divisions; a zero
//   denominator skips all divisions. All run on the single shared restoring divider.
// Throughput: one request at a time; busy stays high until the strobe.
// Results: rsp_valid high for one cycle; the receiver cannot stall.
// Reset: synchronous, active high; returns the sequencer to idle.
module rational_reduce_mixed_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrm_pkg::req_type req_data,
   output logic             rsp_valid,
   output rrm_pkg::rsp_type rsp_data
);

   rrm_pkg::cmd_type cmd;
   rrm_pkg::sts_type sts;

   rrm_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrm_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/rrm_datapath.sv =====
// ----------------------------------------------------------------------------
// rrm_datapath
// Operand registers and a shared restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrm_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rrm_pkg::req_type req_data,
   input  rrm_pkg::cmd_type cmd,
   output rrm_pkg::sts_type sts,
   output rrm_pkg::rsp_type rsp_data
);

   localparam int unsigned W  = rrm_pkg::DATA_W;
   localparam int unsigned CW = $clog2(W + 1);

   logic          neg_ff, neg_in;      // sign of result numerator
   logic          zden_ff, zden_in;
   logic [W-1:0]  mag_ff, mag_in;      // |n| after sign move
   logic [W-1:0]  den_ff, den_in;      // |d|
   logic [W-1:0]  ga_ff, ga_in;        // Euclid a
   logic [W-1:0]  gb_ff, gb_in;        // Euclid b
   logic [W-1:0]  rnm_ff, rnm_in;      // |rn|
   logic [W-1:0]  rd_ff, rd_in;
   logic [W-1:0]  wq_ff, wq_in;        // |whole|
   logic [W-1:0]  wr_ff, wr_in;        // |rem|

   // divider
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  dv_ff, dv_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          fin_ff, fin_in;

   logic [W-1:0]  dvd_sel, dvs_sel;
   logic [W:0]    trial;
   logic [W:0]    shifted;

   logic [W-1:0]  n_abs, d_abs;

   always_comb begin
      n_abs = req_data.numerator[W-1]   ? (~req_data.numerator + 1'b1)
                                        : req_data.numerator;
      d_abs = req_data.denominator[W-1] ? (~req_data.denominator + 1'b1)
                                        : req_data.denominator;
   end

   always_comb begin
      case (cmd.dsel)
         rrm_pkg::DSEL_GCD: begin
            dvd_sel = ga_ff;  dvs_sel = gb_ff;
         end
         rrm_pkg::DSEL_NUM: begin
            dvd_sel = mag_ff; dvs_sel = ga_ff;
         end
         rrm_pkg::DSEL_DEN: begin
            dvd_sel = den_ff; dvs_sel = ga_ff;
         end
         rrm_pkg::DSEL_WHOLE: begin
            dvd_sel = rnm_ff; dvs_sel = rd_ff;
         end
         default: begin
            dvd_sel = ga_ff;  dvs_sel = gb_ff;
         end
      endcase
   end

   always_comb begin
      shifted = {r_ff, q_ff[W-1]};
      trial   = shifted - {1'b0, dv_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      if (cmd.div_start) begin
         q_in   = dvd_sel;
         r_in   = '0;
         dv_in  = dvs_sel;
         cnt_in = CW'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = shifted[W-1:0];
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_comb begin
      neg_in  = neg_ff;
      zden_in = zden_ff;
      mag_in  = mag_ff;
      den_in  = den_ff;
      ga_in   = ga_ff;
      gb_in   = gb_ff;
      rnm_in  = rnm_ff;
      rd_in   = rd_ff;
      wq_in   = wq_ff;
      wr_in   = wr_ff;
      if (cmd.load) begin
         zden_in = (req_data.denominator == '0);
         neg_in  = req_data.numerator[W-1] ^ req_data.denominator[W-1];
         mag_in  = n_abs;
         den_in  = d_abs;
         ga_in   = n_abs;
         gb_in   = d_abs;
      end else if (cmd.div_store) begin
         case (cmd.dsel)
            rrm_pkg::DSEL_GCD: begin
               ga_in = gb_ff;
               gb_in = r_ff;
            end
            rrm_pkg::DSEL_NUM:   rnm_in = q_ff;
            rrm_pkg::DSEL_DEN:   rd_in  = q_ff;
            rrm_pkg::DSEL_WHOLE: begin
               wq_in = q_ff;
               wr_in = r_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         cnt_ff <= cnt_in;
      end
      q_ff    <= q_in;
      r_ff    <= r_in;
      dv_ff   <= dv_in;
      neg_ff  <= neg_in;
      zden_ff <= zden_in;
      mag_ff  <= mag_in;
      den_ff  <= den_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      rnm_ff  <= rnm_in;
      rd_ff   <= rd_in;
      wq_ff   <= wq_in;
      wr_ff   <= wr_in;
   end

   assign sts.zero_den = zden_ff;
   assign sts.b_zero   = (gb_ff == '0);
   assign sts.div_done = fin_ff;

   // zero numerator: magnitudes are 0, so signs fall out as zero too
   always_comb begin
      if (zden_ff) begin
         rsp_data = '0;
         rsp_data.zero_denominator = 1'b1;
      end else begin
         rsp_data.reduced_numerator   = neg_ff ? (~rnm_ff + 1'b1) : rnm_ff;
         rsp_data.reduced_denominator = rd_ff[W-2:0];
         rsp_data.whole_part          = neg_ff ? (~wq_ff + 1'b1) : wq_ff;
         rsp_data.fraction_remainder  = neg_ff ? (~wr_ff + 1'b1) : wr_ff;
         rsp_data.zero_denominator    = 1'b0;
      end
   end

   `ASSERT_IMPL(a_start_idle, clock, reset, cmd.div_start |-> !run_ff,
                "divider launched while running")
   `ASSERT_IMPL(a_fin_after_run, clock, reset, fin_ff |-> $past(run_ff),
                "divider finish without a run")
   `ASSERT_IMPL(a_rem_lt_div, clock, reset, fin_ff |-> (r_ff < dv_ff),
                "remainder not below divisor")

endmodule

// ===== rtl/rrm_control.sv =====
// ----------------------------------------------------------------------------
// rrm_control
// Sequencer: Euclid loop, then the reducing and mixed-form divisions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrm_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   input  rrm_pkg::sts_type sts,
   output rrm_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_GCD   = 7'b0000100,
      ST_NUM   = 7'b0001000,
      ST_DEN   = 7'b0010000,
      ST_WHOLE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      issued_ff, issued_in;  // division of this state launched

   always_comb begin
      state_in      = state_ff;
      issued_in     = issued_ff;
      cmd           = '0;
      cmd.dsel      = rrm_pkg::DSEL_GCD;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            issued_in = 1'b0;
            if (sts.zero_den)    state_in = ST_DONE;
            else if (sts.b_zero) state_in = ST_NUM;
            else                 state_in = ST_GCD;
         end
         ST_GCD, ST_NUM, ST_DEN, ST_WHOLE: begin
            case (state_ff)
               ST_GCD:   cmd.dsel = rrm_pkg::DSEL_GCD;
               ST_NUM:   cmd.dsel = rrm_pkg::DSEL_NUM;
               ST_DEN:   cmd.dsel = rrm_pkg::DSEL_DEN;
               default:  cmd.dsel = rrm_pkg::DSEL_WHOLE;
            endcase
            if (!issued_ff) begin
               cmd.div_start = 1'b1;
               issued_in     = 1'b1;
            end else if (sts.div_done) begin
               cmd.div_store = 1'b1;
               issued_in     = 1'b0;
               case (state_ff)
                  ST_GCD:   state_in = ST_CHECK;
                  ST_NUM:   state_in = ST_DEN;
                  ST_DEN:   state_in = ST_WHOLE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_DONE: begin
            cmd.done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = cmd.done;

   `ASSERT_IMPL(a_done_once, clock, reset, rsp_valid |=> !rsp_valid,
                "result strobe longer than one cycle")
   `ASSERT_IMPL(a_load_idle, clock, reset, cmd.load |=> busy,
                "request taken without going busy")
   `ASSERT_ALWAYS(a_one_hot, clock, $onehot(state_ff) || reset,
                  "state register not one-hot")

endmodule
